FILE: rtl/thermal_capped_backlight_ctrl_defines.svh
// assertion macros for the backlight controller checker
`ifndef THERMAL_CAPPED_BACKLIGHT_CTRL_DEFINES_SVH
`define THERMAL_CAPPED_BACKLIGHT_CTRL_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TCBL_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("backlight ctrl check failed");

// antecedent implies consequent in the next cycle
`define TCBL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("backlight ctrl check failed");

`endif

FILE: rtl/tcbl_pkg.sv
// types and constants for the thermal capped backlight controller
package tcbl_pkg;

    typedef enum logic [1:0] {
        KIND_USER  = 2'd0,
        KIND_COOL  = 2'd1,
        KIND_TABLE = 2'd2,
        KIND_IDLE  = 2'd3
    } kind_e;

    typedef enum logic {
        REG_LIMIT = 1'b0,
        REG_MODE  = 1'b1
    } reg_idx_e;

    localparam logic [7:0] FULL_SCALE       = 8'd255;
    localparam logic [7:0] HIGH_CAP         = 8'd255;
    localparam logic [7:0] LOW_CAP          = 8'd175;
    localparam int         HIGH_CAP_ENTRIES = 6;
    localparam logic [7:0] LIMIT_RESET      = 8'd255;
    localparam logic       MODE_RESET       = 1'b1;

    typedef struct packed {
        kind_e      kind;
        logic [7:0] level_value;
        logic [3:0] state_value;
    } in_item_t;

    typedef struct packed {
        logic       apply;
        logic [7:0] drive_value;
        logic       power_up;
        logic       power_down;
        logic [7:0] reported_brightness;
        logic       index_error;
    } out_item_t;

    typedef struct packed {
        logic [7:0] applied_level;
        logic [7:0] requested_level;
        logic [3:0] cooling_state;
        logic [7:0] shown_level;
    } ctrl_state_t;

    typedef struct packed {
        logic       en;
        logic [3:0] idx;
        logic [7:0] value;
    } cap_wr_t;

endpackage

FILE: rtl/tcbl_cap_table.sv
// cap table: one cap per nonzero cooling state, write port and one read port by state number
module tcbl_cap_table
    import tcbl_pkg::*;
#(
    parameter int TRIP_COUNT = 12
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cap_wr_t    wr,
    input  logic [3:0] rd_state,
    output logic [7:0] rd_cap
);

    localparam int IDX_W = (TRIP_COUNT > 1) ? $clog2(TRIP_COUNT) : 1;

    logic [7:0]       cap_reg [TRIP_COUNT];
    logic [3:0]       rd_off;
    logic [IDX_W-1:0] rd_idx;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < TRIP_COUNT; i++) begin
            if (!aresetn) begin
                cap_reg[i] <= (i < HIGH_CAP_ENTRIES) ? HIGH_CAP : LOW_CAP;
            end else if (wr.en && wr.idx == 4'(i)) begin
                cap_reg[i] <= wr.value;
            end
        end
    end

    // state s uses entry s-1, state zero has no cap
    assign rd_off = rd_state - 4'd1;
    assign rd_idx = rd_off[IDX_W-1:0];
    assign rd_cap = (rd_state == 4'd0) ? 8'd0 : cap_reg[rd_idx];

endmodule

FILE: rtl/tcbl_update.sv
// per-item update: next controller state, table write and result fields
module tcbl_update
    import tcbl_pkg::*;
#(
    parameter int TRIP_COUNT = 12
) (
    input  in_item_t    item,
    input  ctrl_state_t cur,
    input  logic [7:0]  brightness_limit,
    input  logic        drive_mode,
    input  logic [7:0]  rd_cap,
    output logic [3:0]  rd_state,
    output ctrl_state_t nxt,
    output cap_wr_t     cap_wr,
    output out_item_t   result
);

    localparam logic [3:0] TRIP_MAX = 4'(TRIP_COUNT);

    logic [3:0]  clamped_state;
    logic [7:0]  target;
    logic        do_apply;
    logic        drive_en;
    logic [15:0] product;
    logic [16:0] quot_sum;
    logic [7:0]  scaled;

    assign clamped_state = (item.state_value > TRIP_MAX) ? TRIP_MAX : item.state_value;

    // a state change looks up the cap of the new state, a request that of the current one
    assign rd_state = (item.kind == KIND_COOL) ? clamped_state : cur.cooling_state;

    always_comb begin
        nxt      = cur;
        target   = item.level_value;
        do_apply = 1'b0;
        cap_wr   = '0;
        result   = '0;

        case (item.kind)
            KIND_USER: begin
                nxt.shown_level     = item.level_value;
                nxt.requested_level = item.level_value;
                do_apply            = 1'b1;
                if (cur.cooling_state != 4'd0 && item.level_value > rd_cap) begin
                    nxt.shown_level = rd_cap;
                    target          = rd_cap;
                    if (cur.applied_level != 8'd0) begin
                        do_apply = 1'b0;
                    end
                end
            end
            KIND_COOL: begin
                if (cur.cooling_state == 4'd0) begin
                    nxt.requested_level = cur.applied_level;
                end
                if (cur.cooling_state != item.state_value) begin
                    nxt.cooling_state = clamped_state;
                    if (clamped_state == 4'd0) begin
                        target   = nxt.requested_level;
                        do_apply = 1'b1;
                    end else begin
                        target   = rd_cap;
                        do_apply = !(rd_cap > nxt.requested_level);
                    end
                end
            end
            KIND_TABLE: begin
                if (32'(item.state_value) >= 32'(TRIP_COUNT)) begin
                    result.index_error = 1'b1;
                end else begin
                    cap_wr.en    = 1'b1;
                    cap_wr.idx   = item.state_value;
                    cap_wr.value = item.level_value;
                end
            end
            default: begin
            end
        endcase

        // x / 255 == (x + (x >> 8) + 1) >> 8 over the 16-bit product range
        product  = 16'(target) * 16'(brightness_limit);
        quot_sum = 17'(product) + 17'(product[15:8]) + 17'd1;
        scaled   = quot_sum[15:8];

        // a repeat of the applied level is skipped
        drive_en = do_apply && (cur.applied_level != target);
        if (drive_en) begin
            result.apply       = 1'b1;
            result.power_up    = (cur.applied_level == 8'd0);
            result.power_down  = (target == 8'd0);
            result.drive_value = (drive_mode && brightness_limit != FULL_SCALE) ? scaled : target;
            nxt.applied_level  = target;
            nxt.shown_level    = target;
        end
        result.reported_brightness = nxt.shown_level;
    end

endmodule

FILE: rtl/thermal_capped_backlight_ctrl.sv
// an accepted item waits in the input register, then moves to the result register that drives m_data
// throughput: one item per cycle while m_ready stays high; a stalled result holds both registers
// the controller state is updated as an item moves from the input to the result register
// reset (aresetn low, synchronous) empties both registers, clears levels and cooling state,
// reloads the default caps and sets brightness_limit to 255 and drive_mode to 1
module thermal_capped_backlight_ctrl
    import tcbl_pkg::*;
#(
    parameter int TRIP_COUNT = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic [7:0]  limit_reg;
    logic        mode_reg;
    logic        cfg_wr;
    reg_idx_e    reg_sel;

    logic        in_valid_reg;
    in_item_t    in_data_reg;
    logic        out_valid_reg;
    out_item_t   out_data_reg;
    logic        advance;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    out_item_t   result;
    cap_wr_t     cap_wr;
    logic [3:0]  rd_state;
    logic [7:0]  rd_cap;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_e'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            mode_reg  <= MODE_RESET;
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_LIMIT: limit_reg <= pwdata[7:0];
                REG_MODE:  mode_reg  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_sel)
            REG_LIMIT: prdata = {24'd0, limit_reg};
            REG_MODE:  prdata = {31'd0, mode_reg};
            default:   prdata = '0;
        endcase
    end

    // the result register frees up when it is empty or its transfer completes
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    tcbl_update #(
        .TRIP_COUNT(TRIP_COUNT)
    ) u_update (
        .item             (in_data_reg),
        .cur              (state_reg),
        .brightness_limit (limit_reg),
        .drive_mode       (mode_reg),
        .rd_cap           (rd_cap),
        .rd_state         (rd_state),
        .nxt              (state_next),
        .cap_wr           (cap_wr),
        .result           (result)
    );

    cap_wr_t cap_wr_gated;
    assign cap_wr_gated = '{en: cap_wr.en && advance, idx: cap_wr.idx, value: cap_wr.value};

    tcbl_cap_table #(
        .TRIP_COUNT(TRIP_COUNT)
    ) u_cap_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (cap_wr_gated),
        .rd_state (rd_state),
        .rd_cap   (rd_cap)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: rtl/tcbl_checker.sv
// port-level checks for the backlight controller result channel, bound to the top level
`include "thermal_capped_backlight_ctrl_defines.svh"

module tcbl_checker
    import tcbl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // a stalled result holds
    `TCBL_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // nothing driven means no drive value and no power events
    `TCBL_ASSERT_SAME(a_idle_quiet, aclk, aresetn, m_valid && !m_data.apply, m_data.drive_value == 8'd0 && !m_data.power_up && !m_data.power_down)

    // power events only come with a driven level
    `TCBL_ASSERT_SAME(a_power_apply, aclk, aresetn, m_valid && (m_data.power_up || m_data.power_down), m_data.apply && !(m_data.power_up && m_data.power_down))

    // a rejected table write never drives
    `TCBL_ASSERT_SAME(a_err_no_apply, aclk, aresetn, m_valid && m_data.index_error, !m_data.apply)

    // powering down reports a zero brightness
    `TCBL_ASSERT_SAME(a_down_zero, aclk, aresetn, m_valid && m_data.power_down, m_data.reported_brightness == 8'd0 && m_data.drive_value == 8'd0)

endmodule

bind thermal_capped_backlight_ctrl tcbl_checker u_tcbl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

FILE: dv/thermal_capped_backlight_ctrl_tb.sv
// self-checking testbench for the thermal capped backlight controller
`timescale 1ns / 1ps

module thermal_capped_backlight_ctrl_tb;
    import tcbl_pkg::*;

    localparam int TRIPS        = 12;
    localparam int PHASE_ITEMS  = 115;
    localparam int PHASES       = 6;
    localparam int SHOWN_ERRORS = 10;

    // tracks the controller state and the updates it should emit
    class brightness_tracker;
        logic [7:0] applied_lvl;
        logic [7:0] requested_lvl;
        logic [7:0] shown_lvl;
        logic [3:0] cool_state;
        logic [7:0] caps [TRIPS];
        logic [7:0] limit_reg;
        logic       mode_reg;
        out_item_t  pending_updates [$];
        int         mismatches;

        function new();
            applied_lvl   = '0;
            requested_lvl = '0;
            shown_lvl     = '0;
            cool_state    = '0;
            for (int i = 0; i < TRIPS; i++) begin
                caps[i] = (i < HIGH_CAP_ENTRIES) ? HIGH_CAP : LOW_CAP;
            end
            limit_reg  = LIMIT_RESET;
            mode_reg   = MODE_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(reg_idx_e idx, logic [7:0] val);
            case (idx)
                REG_LIMIT: limit_reg = val;
                REG_MODE:  mode_reg  = val[0];
                default: ;
            endcase
        endfunction

        function logic [7:0] cap_of(logic [3:0] s);
            if (s == 4'd0 || int'(s) > TRIPS) return 8'd0;
            return caps[int'(s) - 1];
        endfunction

        function void drive_level(logic [7:0] lvl, inout out_item_t upd);
            logic [15:0] scaled;
            logic [7:0]  last;
            last = applied_lvl;
            if (last == 8'd0 && lvl != 8'd0) begin
                upd.power_up = 1'b1;
            end else if (last == lvl) begin
                return;
            end
            scaled = {8'd0, lvl};
            if (mode_reg && limit_reg != FULL_SCALE) begin
                scaled = ({8'd0, lvl} * {8'd0, limit_reg}) / 16'd255;
            end
            upd.apply       = 1'b1;
            upd.drive_value = scaled[7:0];
            if (last != 8'd0 && lvl == 8'd0) upd.power_down = 1'b1;
            applied_lvl = lvl;
            shown_lvl   = lvl;
        endfunction

        function void take_request(in_item_t req);
            out_item_t  upd;
            logic [7:0] lvl;
            logic [7:0] cap;
            logic       go;
            upd = '0;
            lvl = req.level_value;
            go  = 1'b1;
            case (req.kind)
                KIND_USER: begin
                    shown_lvl     = lvl;
                    requested_lvl = lvl;
                    if (cool_state != 4'd0) begin
                        cap = cap_of(cool_state);
                        if (lvl > cap) begin
                            shown_lvl = cap;
                            if (applied_lvl != 8'd0) go = 1'b0;
                            else lvl = cap;
                        end
                    end
                    if (go) drive_level(lvl, upd);
                end
                KIND_COOL: begin
                    if (cool_state == 4'd0) requested_lvl = applied_lvl;
                    if (cool_state != req.state_value) begin
                        cool_state = (int'(req.state_value) > TRIPS) ? 4'(TRIPS)
                                                                     : req.state_value;
                        if (cool_state == 4'd0) begin
                            lvl = requested_lvl;
                        end else begin
                            lvl = cap_of(cool_state);
                            if (lvl > requested_lvl) go = 1'b0;
                        end
                        if (go) drive_level(lvl, upd);
                    end
                end
                KIND_TABLE: begin
                    if (int'(req.state_value) >= TRIPS) upd.index_error = 1'b1;
                    else caps[req.state_value] = lvl;
                end
                default: ;
            endcase
            upd.reported_brightness = shown_lvl;
            pending_updates.push_back(upd);
        endfunction

        function string show(out_item_t u);
            return $sformatf("apply=%0d drive=%0d up=%0d down=%0d shown=%0d idx_err=%0d",
                             u.apply, u.drive_value, u.power_up, u.power_down,
                             u.reported_brightness, u.index_error);
        endfunction

        function void match_update(out_item_t got);
            out_item_t want;
            if (pending_updates.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("unexpected update: %s", show(got));
                end
                return;
            end
            want = pending_updates.pop_front();
            if (got.apply !== want.apply || got.drive_value !== want.drive_value ||
                got.power_up !== want.power_up || got.power_down !== want.power_down ||
                got.reported_brightness !== want.reported_brightness ||
                got.index_error !== want.index_error) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("update mismatch: expected %s", show(want));
                    $display("                 actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;

    int stall_pct  = 0;
    int gap_pct    = 0;
    int stall_left = 0;

    brightness_tracker tracker = new();

    thermal_capped_backlight_ctrl #(
        .TRIP_COUNT(TRIPS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // both transfers are seen with pre-edge values
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) tracker.take_request(s_data);
            if (m_valid && m_ready) tracker.match_update(m_data);
        end
    end

    // result side back-pressure, with an occasional long stall
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_ready <= 1'b0;
            if ($urandom_range(0, 15) == 0) stall_left <= $urandom_range(10, 40);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    task automatic send_item(kind_e k, logic [7:0] lvl, logic [3:0] sv);
        int       gap;
        in_item_t req;
        gap             = pick_gap();
        req.kind        = k;
        req.level_value = lvl;
        req.state_value = sv;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random();
        int         r;
        kind_e      k;
        logic [7:0] lvl;
        logic [3:0] sv;
        r = $urandom_range(0, 99);
        if (r < 45) k = KIND_USER;
        else if (r < 75) k = KIND_COOL;
        else if (r < 95) k = KIND_TABLE;
        else k = KIND_IDLE;
        r = $urandom_range(0, 9);
        if (r == 0) lvl = 8'd0;
        else if (r == 1) lvl = 8'hFF;
        else if (r == 2) lvl = 8'($urandom_range(174, 176));
        else lvl = 8'($urandom_range(0, 255));
        sv = 4'($urandom_range(0, 15));
        // keep cooling states and table indexes mostly in range
        if ((k == KIND_COOL || k == KIND_TABLE) && $urandom_range(0, 99) < 85) begin
            sv = 4'($urandom_range(0, TRIPS - 1));
            if (k == KIND_COOL && $urandom_range(0, 3) == 0) sv = 4'd0;
        end
        send_item(k, lvl, sv);
    endtask

    task automatic reg_write(reg_idx_e idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(idx, val);
    endtask

    // first edge lets the monitor log the last transfer before the queue is read
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_updates.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] limits [PHASES];
        logic       modes  [PHASES];
        limits = '{8'd0, 8'd128, 8'd255, 8'd1, 8'd254, 8'd0};
        modes  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
        limits[PHASES-1] = 8'($urandom_range(0, 255));
        modes[PHASES-1]  = 1'($urandom_range(0, 1));

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        m_ready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        stall_pct = 30;
        gap_pct   = 30;
        send_item(KIND_USER,  8'd0,   4'd0);
        send_item(KIND_USER,  8'd255, 4'd0);
        send_item(KIND_USER,  8'd255, 4'd0);
        send_item(KIND_USER,  8'd0,   4'd0);
        send_item(KIND_USER,  8'd100, 4'd0);
        send_item(KIND_COOL,  8'd0,   4'd3);
        send_item(KIND_COOL,  8'd0,   4'd7);
        send_item(KIND_TABLE, 8'd50,  4'd6);
        // above the cap while lit: only the shown level drops
        send_item(KIND_USER,  8'd200, 4'd0);
        send_item(KIND_COOL,  8'd0,   4'd7);
        send_item(KIND_COOL,  8'd0,   4'd0);
        send_item(KIND_COOL,  8'd0,   4'd15);
        send_item(KIND_USER,  8'd0,   4'd15);
        // above the cap while dark: the cap is applied
        send_item(KIND_USER,  8'd255, 4'd0);
        send_item(KIND_TABLE, 8'd0,   4'd12);
        send_item(KIND_TABLE, 8'd255, 4'd15);
        send_item(KIND_TABLE, 8'd0,   4'd11);
        send_item(KIND_COOL,  8'd0,   4'd13);
        send_item(KIND_IDLE,  8'd255, 4'd15);
        send_item(KIND_COOL,  8'd0,   4'd0);
        send_item(KIND_TABLE, 8'd255, 4'd0);
        send_item(KIND_COOL,  8'd0,   4'd1);
        send_item(KIND_USER,  8'd255, 4'd0);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            reg_write(REG_LIMIT, limits[ph]);
            reg_write(REG_MODE, {7'd0, modes[ph]});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    if ($urandom_range(0, 2) == 0) begin
                        stall_pct = 0;
                        gap_pct   = 0;
                    end else begin
                        stall_pct = $urandom_range(10, 60);
                        gap_pct   = $urandom_range(10, 60);
                    end
                end
                send_random();
            end
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending_updates.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
